@@ sv/gfti_pkg.sv @@
// shared types and constants for the gps fix time interpolator
`default_nettype none
package gfti_pkg;
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// angle wrap limits, degrees times 65536
	localparam logic signed [33:0] HALF_TURN = 34'sd11796480;
	localparam logic signed [33:0] FULL_TURN = 34'sd23592960;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_LATER,
		ST_NO_EARLIER,
		ST_FULL
	} status_t;

	// one stored fix
	typedef struct packed {
		logic [31:0]        tstamp;
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		logic signed [23:0] alt;
		logic [24:0]        heading;
	} fix_rec_t;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage
`default_nettype wire

@@ sv/gfti_div.sv @@
// iterative signed by unsigned divider, one quotient bit per cycle, truncating to zero
`default_nettype none
module gfti_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic signed [63:0]  dividend,
	input  wire logic [31:0]         divisor,
	output logic signed [63:0]       quotient,
	output gfti_pkg::div_stat_t      stat
);
	import gfti_pkg::*;

	logic [31:0]          rem_q;
	logic [63:0]          quo_q;
	logic [31:0]          den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [32:0]          shifted;
	logic [33:0]          diff;
	logic                 ge;

	// one restoring step
	always_comb begin
		shifted = {rem_q, quo_q[63]};
		diff = {1'b0, shifted} - {2'b00, den_q};
		ge = ~diff[33];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63];
			quo_q <= dividend[63] ? 64'(-dividend) : 64'(dividend);
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign quotient = neg_q ? -signed'(quo_q) : signed'(quo_q);
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule
`default_nettype wire

@@ sv/gps_fix_time_interpolator.sv @@
// insert: scans stored fixes, moves later ones up one place, then writes the new fix
// query: scans stored fixes, then interpolates each quantity in turn,
//   with the shared divider run once per quantity
// one transaction at a time; the next may be taken while the result waits at the output
// reset empties the table (fill count to zero) and drops any pending result
`default_nettype none
module gps_fix_time_interpolator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [31:0]        event_time,
	input  wire logic               att_flag,
	input  wire logic signed [23:0] fix_lat,
	input  wire logic signed [24:0] fix_long,
	input  wire logic signed [23:0] fix_alt,
	input  wire logic [24:0]        fix_heading,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [31:0]             out_time,
	output logic signed [23:0]      out_lat,
	output logic signed [25:0]      out_long,
	output logic signed [23:0]      out_alt,
	output logic signed [26:0]      out_heading,
	output logic [31:0]             nearest_gap
);
	import gfti_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_INS_RD, S_INS_CMP, S_INS_DEC, S_SH_RD, S_SH_WR, S_INS_WR,
		S_Q_RD, S_Q_CMP, S_Q_LO_RD, S_Q_LO, S_Q_PREP, S_MUL1, S_MUL2,
		S_DIV_GO, S_DIV_WAIT, S_DONE
	} state_t;

	state_t state_q;

	fix_rec_t mem [TABLE_DEPTH];
	fix_rec_t rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	fix_rec_t wr_data;

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] pos_m1;
	logic [CNT_W-1:0] idx_m1;
	logic [31:0] t_q;
	fix_rec_t new_q;
	fix_rec_t lo_q;
	fix_rec_t up_q;
	logic [31:0] num_q;
	logic [31:0] den_q;
	logic signed [33:0] up_long_q;
	logic signed [33:0] up_head_q;
	logic [1:0] k_q;
	logic signed [63:0] p_q;
	logic signed [63:0] n_q;

	status_t res_status_q;
	logic signed [23:0] res_lat_q;
	logic signed [25:0] res_long_q;
	logic signed [23:0] res_alt_q;
	logic signed [26:0] res_head_q;
	logic [31:0] res_gap_q;

	logic out_valid_q;
	status_t out_status_q;
	logic [31:0] out_time_q;
	logic signed [23:0] out_lat_q;
	logic signed [25:0] out_long_q;
	logic signed [23:0] out_alt_q;
	logic signed [26:0] out_head_q;
	logic [31:0] out_gap_q;

	logic signed [33:0] lo_l, up_l, ul1, ul2;
	logic signed [33:0] lo_h, up_h, uh1, uh2;
	logic [31:0] num_c, upgap_c;
	logic signed [33:0] lo_sel, up_sel, d_sel;
	logic signed [33:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [66:0] mul_p;
	logic div_start;
	logic signed [63:0] div_quo;
	div_stat_t div_stat;

	assign pos_m1 = pos_q - 1'b1;
	assign idx_m1 = idx_q - 1'b1;

	// table read address
	always_comb begin
		case (state_q)
			S_SH_RD:   rd_addr = idx_m1[IDX_W-1:0];
			S_Q_LO_RD: rd_addr = pos_m1[IDX_W-1:0];
			default:   rd_addr = pos_q[IDX_W-1:0];
		endcase
	end

	// table write port: moves during the shift, new fix at the end
	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_q;
		case (state_q)
			S_SH_WR: wr_en = 1'b1;
			S_INS_WR: begin
				wr_en = 1'b1;
				wr_addr = pos_q[IDX_W-1:0];
				wr_data = new_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	// fix table
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// angle unwrap of the later fix and the time differences
	always_comb begin
		lo_l = 34'(lo_q.lon);
		up_l = 34'(up_q.lon);
		ul1 = (up_l - lo_l > HALF_TURN) ? up_l - FULL_TURN : up_l;
		ul2 = (ul1 - lo_l < -HALF_TURN) ? ul1 + FULL_TURN : ul1;
		lo_h = signed'(34'(lo_q.heading));
		up_h = signed'(34'(up_q.heading));
		uh1 = (up_h - lo_h > HALF_TURN) ? up_h - FULL_TURN : up_h;
		uh2 = (uh1 - lo_h < -HALF_TURN) ? uh1 + FULL_TURN : uh1;
		num_c = t_q - lo_q.tstamp;
		upgap_c = up_q.tstamp - t_q;
	end

	// quantity selection and the shared multiplier
	always_comb begin
		case (k_q)
			2'd0: begin
				lo_sel = 34'(lo_q.lat);
				up_sel = 34'(up_q.lat);
			end
			2'd1: begin
				lo_sel = 34'(lo_q.lon);
				up_sel = up_long_q;
			end
			2'd2: begin
				lo_sel = 34'(lo_q.alt);
				up_sel = 34'(up_q.alt);
			end
			default: begin
				lo_sel = signed'(34'(lo_q.heading));
				up_sel = up_head_q;
			end
		endcase
		d_sel = up_sel - lo_sel;
		if (state_q == S_MUL1) begin
			mul_a = lo_sel;
			mul_b = signed'({1'b0, den_q});
		end else begin
			mul_a = d_sel;
			mul_b = signed'({1'b0, num_q});
		end
		mul_p = mul_a * mul_b;
	end

	assign div_start = (state_q == S_DIV_GO);

	gfti_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (den_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output drained; the hand-over state below reloads it itself
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						t_q <= event_time;
						new_q <= '{event_time, fix_lat, fix_long, fix_alt, fix_heading};
						pos_q <= '0;
						res_status_q <= ST_OK;
						res_lat_q <= '0;
						res_long_q <= '0;
						res_alt_q <= '0;
						res_head_q <= '0;
						res_gap_q <= '0;
						if (action) state_q <= S_Q_RD;
						else if (att_flag) state_q <= S_DONE;
						else state_q <= S_INS_RD;
					end
				end
				// insert: find first entry not earlier
				S_INS_RD: begin
					if (pos_q == fill_q) state_q <= S_INS_DEC;
					else state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (rd_q.tstamp < t_q) begin
						pos_q <= pos_q + 1'b1;
						state_q <= S_INS_RD;
					end else if (rd_q.tstamp == t_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_INS_DEC;
					end
				end
				S_INS_DEC: begin
					idx_q <= fill_q;
					if (fill_q == CNT_W'(TABLE_DEPTH)) begin
						res_status_q <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SH_RD;
					end
				end
				// move later entries up one place
				S_SH_RD: begin
					if (idx_q == pos_q) state_q <= S_INS_WR;
					else state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					idx_q <= idx_m1;
					state_q <= S_SH_RD;
				end
				S_INS_WR: begin
					fill_q <= fill_q + 1'b1;
					state_q <= S_DONE;
				end
				// query: find first entry strictly later
				S_Q_RD: begin
					if (pos_q == fill_q) begin
						res_status_q <= ST_NO_LATER;
						state_q <= S_DONE;
					end else begin
						state_q <= S_Q_CMP;
					end
				end
				S_Q_CMP: begin
					if (rd_q.tstamp <= t_q) begin
						pos_q <= pos_q + 1'b1;
						state_q <= S_Q_RD;
					end else begin
						up_q <= rd_q;
						if (pos_q == '0) begin
							res_status_q <= ST_NO_EARLIER;
							state_q <= S_DONE;
						end else begin
							state_q <= S_Q_LO_RD;
						end
					end
				end
				S_Q_LO_RD: state_q <= S_Q_LO;
				S_Q_LO: begin
					lo_q <= rd_q;
					state_q <= S_Q_PREP;
				end
				S_Q_PREP: begin
					num_q <= num_c;
					den_q <= up_q.tstamp - lo_q.tstamp;
					res_gap_q <= (num_c < upgap_c) ? num_c : upgap_c;
					up_long_q <= ul2;
					up_head_q <= uh2;
					k_q <= '0;
					state_q <= S_MUL1;
				end
				// numerator lo*den + (up-lo)*num, then divide by den
				S_MUL1: begin
					p_q <= mul_p[63:0];
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					n_q <= p_q + mul_p[63:0];
					state_q <= S_DIV_GO;
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_stat.done) begin
						case (k_q)
							2'd0: res_lat_q <= div_quo[23:0];
							2'd1: res_long_q <= div_quo[25:0];
							2'd2: res_alt_q <= div_quo[23:0];
							default: res_head_q <= div_quo[26:0];
						endcase
						k_q <= k_q + 1'b1;
						if (k_q == 2'd3) state_q <= S_DONE;
						else state_q <= S_MUL1;
					end
				end
				// hand the result to the output register
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_time_q <= t_q;
						out_lat_q <= res_lat_q;
						out_long_q <= res_long_q;
						out_alt_q <= res_alt_q;
						out_head_q <= res_head_q;
						out_gap_q <= res_gap_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign out_time = out_time_q;
	assign out_lat = out_lat_q;
	assign out_long = out_long_q;
	assign out_alt = out_alt_q;
	assign out_heading = out_head_q;
	assign nearest_gap = out_gap_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count past table depth");
	a_fill_only_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_INS_WR |=> fill_q == $past(fill_q))
		else $error("fill count moved outside insert write");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_stat.busy)
		else $error("divider busy while sequencer idle");
`endif
endmodule
`default_nettype wire

@@ sim/gps_fix_time_interpolator_tb.sv @@
// testbench for the gps fix time interpolator: directed table then random fixes and queries
`default_nettype none
module gps_fix_time_interpolator_tb;
	import gfti_pkg::*;

	// one input transaction
	typedef struct packed {
		logic               action;
		logic [31:0]        tm;
		logic               flag;
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		logic signed [23:0] alt;
		logic [24:0]        hdg;
	} fix_req_t;

	// one result transaction
	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        tm;
		logic signed [23:0] lat;
		logic signed [25:0] lon;
		logic signed [23:0] alt;
		logic signed [26:0] hdg;
		logic [31:0]        gap;
	} fix_result_t;

	// directed row; the expected status is typed in only where obvious
	typedef struct {
		fix_req_t req;
		bit       typed;
		status_t  st;
	} dir_row_t;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [31:0] event_time = '0;
	logic att_flag = 1'b0;
	logic signed [23:0] fix_lat = '0;
	logic signed [24:0] fix_long = '0;
	logic signed [23:0] fix_alt = '0;
	logic [24:0] fix_heading = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [31:0] out_time;
	logic signed [23:0] out_lat;
	logic signed [25:0] out_long;
	logic signed [23:0] out_alt;
	logic signed [26:0] out_heading;
	logic [31:0] nearest_gap;

	fix_rec_t fix_table[$];
	fix_result_t pending_fixes[$];
	int failures = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	int n_inserts = 0;
	int n_queries = 0;
	bit calm = 1'b0;

	gps_fix_time_interpolator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .event_time(event_time), .att_flag(att_flag),
		.fix_lat(fix_lat), .fix_long(fix_long), .fix_alt(fix_alt),
		.fix_heading(fix_heading),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .out_time(out_time), .out_lat(out_lat),
		.out_long(out_long), .out_alt(out_alt), .out_heading(out_heading),
		.nearest_gap(nearest_gap)
	);

	// clock
	always #5 clk = ~clk;

	// linear interpolation, truncated toward zero
	function automatic longint lerp(longint lo, longint up, longint num, longint den);
		return (lo * den + (up - lo) * num) / den;
	endfunction

	// move the later angle by a full turn when the difference passes half a turn
	function automatic longint unwrap_angle(longint lo, longint up);
		longint u;
		u = up;
		if (u - lo > longint'(HALF_TURN)) u -= longint'(FULL_TURN);
		if (u - lo < -longint'(HALF_TURN)) u += longint'(FULL_TURN);
		return u;
	endfunction

	// predicted result of one transaction; inserts update the sorted fix table
	function automatic fix_result_t interpolate_fix(fix_req_t r);
		fix_result_t res;
		fix_rec_t rec, lo, up;
		int pos;
		longint num, den, upgap;
		res = '0;
		res.tm = r.tm;
		pos = 0;
		if (r.action == ACT_INSERT) begin
			if (r.flag) return res;
			while (pos < fix_table.size() && fix_table[pos].tstamp < r.tm) pos++;
			if (pos < fix_table.size() && fix_table[pos].tstamp == r.tm) return res;
			if (fix_table.size() >= TABLE_DEPTH) begin
				res.status = ST_FULL;
				return res;
			end
			rec.tstamp = r.tm;
			rec.lat = r.lat;
			rec.lon = r.lon;
			rec.alt = r.alt;
			rec.heading = r.hdg;
			fix_table.insert(pos, rec);
			return res;
		end
		while (pos < fix_table.size() && fix_table[pos].tstamp <= r.tm) pos++;
		if (pos >= fix_table.size()) begin
			res.status = ST_NO_LATER;
			return res;
		end
		if (pos == 0) begin
			res.status = ST_NO_EARLIER;
			return res;
		end
		lo = fix_table[pos - 1];
		up = fix_table[pos];
		num = longint'(r.tm) - longint'(lo.tstamp);
		den = longint'(up.tstamp) - longint'(lo.tstamp);
		upgap = longint'(up.tstamp) - longint'(r.tm);
		res.status = ST_OK;
		res.lat = 24'(lerp(lo.lat, up.lat, num, den));
		res.lon = 26'(lerp(lo.lon, unwrap_angle(lo.lon, up.lon), num, den));
		res.alt = 24'(lerp(lo.alt, up.alt, num, den));
		res.hdg = 27'(lerp(longint'(lo.heading),
			unwrap_angle(longint'(lo.heading), longint'(up.heading)), num, den));
		res.gap = 32'((num < upgap) ? num : upgap);
		return res;
	endfunction

	// drive one transaction, wait for acceptance and store its expected result
	task automatic send_fix(input fix_req_t r, input bit typed, input status_t st);
		fix_result_t want;
		if (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		action <= r.action;
		event_time <= r.tm;
		att_flag <= r.flag;
		fix_lat <= r.lat;
		fix_long <= r.lon;
		fix_alt <= r.alt;
		fix_heading <= r.hdg;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		want = interpolate_fix(r);
		if (typed) begin
			want = '0;
			want.status = st;
			want.tm = r.tm;
		end
		if (r.action == ACT_INSERT) n_inserts++;
		else n_queries++;
		pending_fixes.push_back(want);
	endtask

	// hold off the sender until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_fixes.size() != 0) @(posedge clk);
	endtask

	// field values, mostly in range with some raw bit patterns
	function automatic fix_req_t random_fix(logic act, logic [31:0] t);
		fix_req_t r;
		r.action = act;
		r.tm = t;
		r.flag = ($urandom_range(99) < 10);
		if ($urandom_range(99) < 85) begin
			r.lat = 24'(int'($urandom_range(11796480)) - 5898240);
			r.lon = 25'(int'($urandom_range(23592960)) - 11796480);
			r.alt = 24'(int'($urandom_range(5100000)) - 100000);
			r.hdg = 25'($urandom_range(23592960));
		end else begin
			r.lat = 24'($urandom);
			r.lon = 25'($urandom);
			r.alt = 24'($urandom);
			r.hdg = 25'($urandom);
		end
		return r;
	endfunction

	// pick a time that usually falls between stored fixes
	function automatic logic [31:0] query_time();
		int idx;
		int unsigned span;
		if (fix_table.size() == 0 || $urandom_range(99) < 10) return $urandom;
		idx = $urandom_range(fix_table.size() - 1);
		if ($urandom_range(99) < 15) return fix_table[idx].tstamp;
		if (idx + 1 < fix_table.size())
			span = fix_table[idx + 1].tstamp - fix_table[idx].tstamp;
		else
			span = 100;
		return fix_table[idx].tstamp + $urandom_range(span);
	endfunction

	// result receiver with random back-pressure
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 29);
	end

	// field comparison
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			failures++;
		end
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		fix_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_fixes.size() == 0) begin
				$error("result transaction with none expected, time 0x%08h", out_time);
				failures++;
			end else begin
				want = pending_fixes.pop_front();
				status_seen[status]++;
				check_field("status", 32'(want.status), 32'(status));
				check_field("out_time", want.tm, out_time);
				check_field("out_lat", 32'(want.lat), 32'(out_lat));
				check_field("out_long", 32'(want.lon), 32'(out_long));
				check_field("out_alt", 32'(want.alt), 32'(out_alt));
				check_field("out_heading", 32'(want.hdg), 32'(out_heading));
				check_field("nearest_gap", want.gap, nearest_gap);
			end
		end
	end

	// directed rows: empty table, flag drop, duplicates, extremes, angle wrap
	dir_row_t directed_rows[] = '{
		'{'{ACT_QUERY,  32'd100, 1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b1, ST_NO_LATER},
		'{'{ACT_INSERT, 32'd100, 1'b1, 24'sd5, 25'sd5, 24'sd5, 25'd5}, 1'b1, ST_OK},
		'{'{ACT_QUERY,  32'd100, 1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b1, ST_NO_LATER},
		'{'{ACT_INSERT, 32'd100, 1'b0, 24'sd5898240, 25'sd11796480, -24'sd100000,
			25'd0}, 1'b1, ST_OK},
		'{'{ACT_INSERT, 32'd100, 1'b0, 24'sd1, 25'sd1, 24'sd1, 25'd1}, 1'b1, ST_OK},
		'{'{ACT_QUERY,  32'd50,  1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b1, ST_NO_EARLIER},
		'{'{ACT_QUERY,  32'd100, 1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b1, ST_NO_LATER},
		'{'{ACT_INSERT, 32'd200, 1'b0, -24'sd5898240, -25'sd11796480, 24'sd5000000,
			25'd23592960}, 1'b1, ST_OK},
		'{'{ACT_QUERY,  32'd150, 1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b0, ST_OK},
		'{'{ACT_QUERY,  32'd100, 1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b0, ST_OK},
		'{'{ACT_QUERY,  32'd199, 1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b0, ST_OK},
		'{'{ACT_INSERT, 32'd0,   1'b0, 24'h7fffff, 25'h0ffffff, 24'h800000,
			25'h1ffffff}, 1'b1, ST_OK},
		'{'{ACT_INSERT, 32'hffffffff, 1'b0, 24'h800000, 25'h1000000, 24'h7fffff,
			25'd0}, 1'b1, ST_OK},
		'{'{ACT_QUERY,  32'd0,   1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b0, ST_OK},
		'{'{ACT_QUERY,  32'd37,  1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b0, ST_OK},
		'{'{ACT_QUERY,  32'hfffffffe, 1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b0, ST_OK},
		'{'{ACT_QUERY,  32'h80000000, 1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b0, ST_OK},
		'{'{ACT_QUERY,  32'hffffffff, 1'b0, 24'sd0, 25'sd0, 24'sd0, 25'd0}, 1'b1, ST_NO_LATER}
	};

	// stimulus
	initial begin
		fix_req_t r;
		logic [31:0] t;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_fix(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].st);
		drain_results();
		for (int i = 0; i < 430; i++) begin
			calm = (i >= 150 && i < 250);
			if (i == 300) drain_results();
			if ($urandom_range(99) < 45) begin
				// insert: mostly a dense time window, some duplicates and wide times
				case ($urandom_range(9))
					0: t = $urandom;
					1: t = (fix_table.size() != 0) ?
						fix_table[$urandom_range(fix_table.size() - 1)].tstamp : $urandom;
					default: t = 32'd1000 + $urandom_range(1 << 20);
				endcase
				r = random_fix(ACT_INSERT, t);
			end else begin
				r = random_fix(ACT_QUERY, query_time());
			end
			send_fix(r, 1'b0, ST_OK);
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		while (pending_fixes.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		$display("%0d inserts and %0d queries, %0d fixes stored", n_inserts, n_queries,
			fix_table.size());
		$display("results: %0d ok, %0d no later fix, %0d no earlier fix, %0d full",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog
	initial begin
		#60000000;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
